@@ hdl/brb_pkg.sv @@
// Package for the byte ring buffer: action and status codes, the
// control-to-memory request struct, the occupancy view and index helpers.
// No dependencies.
`default_nettype none

package brb_pkg;

  localparam int IDX_W = 10;
  localparam int CNT_W = 10;
  localparam int BYTE_W = 8;
  localparam logic [IDX_W-1:0] BUF_SIZE_RST = 10'd1023;

  // Action codes
  localparam logic [2:0] ACT_NOP  = 3'd0;
  localparam logic [2:0] ACT_PUT  = 3'd1;
  localparam logic [2:0] ACT_GET  = 3'd2;
  localparam logic [2:0] ACT_RDAT = 3'd3;
  localparam logic [2:0] ACT_WRAT = 3'd4;
  localparam logic [2:0] ACT_CONS = 3'd5;
  localparam logic [2:0] ACT_PROD = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BEYOND = 2'd3;

  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_byte;
    logic [IDX_W-1:0]  rd_idx;
  } brb_mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] fill;
    logic [IDX_W-1:0] space;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] rd_len;
    logic [IDX_W-1:0] wr_len;
  } brb_view_t;

  // Occupancy and slice lengths for read index r, write index w, capacity s.
  function automatic brb_view_t slice_view(input logic [IDX_W-1:0] r,
                                           input logic [IDX_W-1:0] w,
                                           input logic [IDX_W-1:0] s);
    logic [IDX_W:0] cells;
    logic [IDX_W:0] fill;
    logic [IDX_W:0] space;
    logic [IDX_W:0] rl;
    logic [IDX_W:0] wl;
    brb_view_t      v;
    cells = {1'b0, s} + 1'b1;
    if (r <= w) begin
      fill = {1'b0, w} - {1'b0, r};
      rl   = {1'b0, w} - {1'b0, r};
    end else begin
      fill = cells - ({1'b0, r} - {1'b0, w});
      rl   = cells - {1'b0, r};
    end
    if (w >= r) begin
      wl = cells - {1'b0, w} - ((r == '0) ? 1'b1 : 1'b0);
    end else begin
      wl = {1'b0, r} - {1'b0, w} - 1'b1;
    end
    space   = {1'b0, s} - fill;
    v.fill  = fill[IDX_W-1:0];
    v.space = space[IDX_W-1:0];
    v.full  = (space == '0);
    v.empty = (r == w);
    v.rd_len = rl[IDX_W-1:0];
    v.wr_len = wl[IDX_W-1:0];
    return v;
  endfunction

  // Move an index by n cells, wrapping to zero past the last cell.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] n,
                                               input logic [IDX_W-1:0] s);
    logic [IDX_W:0] v;
    logic [IDX_W:0] cells;
    cells = {1'b0, s} + 1'b1;
    v = {1'b0, idx} + {1'b0, n};
    return (v >= cells) ? '0 : v[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/brb_mem.sv @@
// Byte store of the ring buffer: one write port, one read port with
// registered read data. Depends on brb_pkg.
`default_nettype none

module brb_mem
  import brb_pkg::*;
#(
  parameter int MEM_CELLS = 1024
) (
  input  wire logic              clk,
  input  wire brb_mem_req_t      req,
  output logic      [BYTE_W-1:0] rd_byte
);

  localparam int AW = (MEM_CELLS > 1) ? $clog2(MEM_CELLS) : 1;

  logic [BYTE_W-1:0] store [MEM_CELLS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[AW'(req.wr_idx)] <= req.wr_byte;
    end
    rd_byte <= store[AW'(req.rd_idx)];
  end

endmodule

`default_nettype wire

@@ hdl/brb_ctrl.sv @@
// Index and capacity registers of the ring buffer, action decode, bound
// checks and memory request generation. Depends on brb_pkg.
`default_nettype none

module brb_ctrl
  import brb_pkg::*;
#(
  parameter int MEM_CELLS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [2:0]        action,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [CNT_W-1:0]  count,
  input  wire logic              cfg_wr_en,
  input  wire logic [IDX_W-1:0]  cfg_wr_data,
  output brb_mem_req_t           mem_req,
  output brb_view_t              view,
  output logic                   done,
  output logic [1:0]             status,
  output logic                   rd_sel,
  output logic [IDX_W-1:0]       read_index,
  output logic [IDX_W-1:0]       write_index
);

  localparam logic [IDX_W-1:0] CAP_MAX =
    (MEM_CELLS - 1 > 1023) ? 10'd1023 : IDX_W'(MEM_CELLS - 1);

  logic [IDX_W-1:0] buf_size;
  logic [IDX_W-1:0] cap;
  logic [IDX_W-1:0] read_index_next;
  logic [IDX_W-1:0] write_index_next;
  logic [1:0]       status_next;
  logic             rd_sel_next;
  logic [IDX_W:0]   rd_sum;
  logic [IDX_W:0]   wr_sum;

  assign cap  = (buf_size > CAP_MAX) ? CAP_MAX : buf_size;
  assign view = slice_view(read_index, write_index, cap);

  assign rd_sum = {1'b0, read_index} + {1'b0, count};
  assign wr_sum = {1'b0, write_index} + {1'b0, count};

  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    status_next      = ST_OK;
    rd_sel_next      = 1'b0;
    mem_req.wr_en    = 1'b0;
    mem_req.wr_idx   = write_index;
    mem_req.wr_byte  = data_byte;
    mem_req.rd_idx   = read_index;
    unique case (action)
      ACT_PUT: begin
        if (view.full) begin
          status_next = ST_FULL;
        end else begin
          mem_req.wr_en    = accept;
          write_index_next = advance(write_index, 10'd1, cap);
        end
      end
      ACT_GET: begin
        if (view.fill == '0) begin
          status_next = ST_EMPTY;
        end else begin
          rd_sel_next     = 1'b1;
          read_index_next = advance(read_index, 10'd1, cap);
        end
      end
      ACT_RDAT: begin
        if (count >= view.rd_len) begin
          status_next = ST_BEYOND;
        end else begin
          rd_sel_next    = 1'b1;
          mem_req.rd_idx = rd_sum[IDX_W-1:0];
        end
      end
      ACT_WRAT: begin
        if (count >= view.wr_len) begin
          status_next = ST_BEYOND;
        end else begin
          mem_req.wr_en  = accept;
          mem_req.wr_idx = wr_sum[IDX_W-1:0];
        end
      end
      ACT_CONS: begin
        if (count > view.rd_len) begin
          status_next = ST_BEYOND;
        end else begin
          read_index_next = advance(read_index, count, cap);
        end
      end
      ACT_PROD: begin
        if (count > view.wr_len) begin
          status_next = ST_BEYOND;
        end else begin
          write_index_next = advance(write_index, count, cap);
        end
      end
      default: begin
        // nop and the unused code leave everything as is
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_size    <= BUF_SIZE_RST;
      read_index  <= '0;
      write_index <= '0;
      done        <= 1'b0;
    end else if (cfg_wr_en) begin
      buf_size    <= cfg_wr_data;
      read_index  <= '0;
      write_index <= '0;
      done        <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        read_index  <= read_index_next;
        write_index <= write_index_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      rd_sel <= rd_sel_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/byte_ring_buffer_with_slices.sv @@
// Byte ring buffer with contiguous read/write slices; top level.
// The result beat shows with done in the cycle after the command is accepted.
// Throughput: one item per cycle whenever busy is low.
// Reset clears both indices, sets the capacity to 1023 and holds busy high
// through reset and in the cycle after it; the byte store is not cleared.
// The receiver cannot stall. Depends on brb_pkg, brb_ctrl, brb_mem.
`default_nettype none

module byte_ring_buffer_with_slices
  import brb_pkg::*;
#(
  parameter int MEM_CELLS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        action,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [CNT_W-1:0]  count,
  // capacity register
  input  wire logic              cfg_wr_en,
  input  wire logic [IDX_W-1:0]  cfg_wr_data,
  // result channel
  output logic                   done,
  output logic [BYTE_W-1:0]      read_data,
  output logic [1:0]             status,
  output logic [IDX_W-1:0]       fill_level,
  output logic [IDX_W-1:0]       free_space,
  output logic                   is_full,
  output logic                   is_empty,
  output logic [IDX_W-1:0]       read_slice_start,
  output logic [IDX_W-1:0]       read_slice_len,
  output logic [IDX_W-1:0]       write_slice_start,
  output logic [IDX_W-1:0]       write_slice_len
);

  logic              accept;
  logic              rd_sel;
  logic [BYTE_W-1:0] mem_byte;
  brb_mem_req_t      mem_req;
  brb_view_t         view;

  // Take a beat whenever start is high and busy is low.
  assign accept = start && !busy;

  // Hold busy high during reset and in the cycle after it only; afterwards every cycle
  // can take a beat, since indices advance at the accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Decode the action, check slice bounds, advance the indices and
  // issue the memory access, all at the accepting edge.
  brb_ctrl #(
    .MEM_CELLS(MEM_CELLS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .data_byte  (data_byte),
    .count      (count),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mem_req    (mem_req),
    .view       (view),
    .done       (done),
    .status     (status),
    .rd_sel     (rd_sel),
    .read_index (read_slice_start),
    .write_index(write_slice_start)
  );

  // Store: a write from the previous beat is visible to the next read,
  // since both go through the same array on successive edges.
  brb_mem #(
    .MEM_CELLS(MEM_CELLS)
  ) u_mem (
    .clk    (clk),
    .req    (mem_req),
    .rd_byte(mem_byte)
  );

  // Drop the memory byte unless the beat was a successful get or read.
  assign read_data = rd_sel ? mem_byte : '0;

  // Occupancy follows the indices as they stand after the last beat.
  assign fill_level      = view.fill;
  assign free_space      = view.space;
  assign is_full         = view.full;
  assign is_empty        = view.empty;
  assign read_slice_len  = view.rd_len;
  assign write_slice_len = view.wr_len;

endmodule

`default_nettype wire

@@ sim/ring_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the byte ring buffer bench: mirrors the ring (capacity, indices,
// byte store), predicts the result beat of every accepted command and compares it.
// Depends on brb_pkg.
module ring_checker
  import brb_pkg::*;
#(
  parameter int MEM_CELLS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        action,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [CNT_W-1:0]  count,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_wr_data,
  input  logic              done,
  input  logic [BYTE_W-1:0] read_data,
  input  logic [1:0]        status,
  input  logic [IDX_W-1:0]  fill_level,
  input  logic [IDX_W-1:0]  free_space,
  input  logic              is_full,
  input  logic              is_empty,
  input  logic [IDX_W-1:0]  read_slice_start,
  input  logic [IDX_W-1:0]  read_slice_len,
  input  logic [IDX_W-1:0]  write_slice_start,
  input  logic [IDX_W-1:0]  write_slice_len,
  output int                mismatches,
  output int                outstanding,
  output int                beats_checked
);

  typedef struct packed {
    logic [BYTE_W-1:0] rdata;
    logic [1:0]        st;
    logic [IDX_W-1:0]  fill;
    logic [IDX_W-1:0]  space;
    logic              full;
    logic              empty;
    logic [IDX_W-1:0]  rs_start;
    logic [IDX_W-1:0]  rs_len;
    logic [IDX_W-1:0]  ws_start;
    logic [IDX_W-1:0]  ws_len;
  } ring_view_t;

  logic [BYTE_W-1:0] shadow_mem [MEM_CELLS];
  int unsigned       cap_q;
  int unsigned       rd_q;
  int unsigned       wr_q;
  ring_view_t        due_views [$];

  function automatic int unsigned usable();
    return (cap_q > MEM_CELLS - 1) ? MEM_CELLS - 1 : cap_q;
  endfunction

  function automatic int unsigned bytes_held(input int unsigned r, input int unsigned w,
                                             input int unsigned n);
    return (r <= w) ? w - r : n - (r - w);
  endfunction

  function automatic int unsigned read_run(input int unsigned r, input int unsigned w,
                                           input int unsigned n);
    return (r <= w) ? w - r : n - r;
  endfunction

  // The write run never touches the read index, so it stops one short of a
  // wrap when the reader sits on cell zero.
  function automatic int unsigned write_run(input int unsigned r, input int unsigned w,
                                            input int unsigned n);
    if (w >= r) begin
      return n - w - ((r == 0) ? 1 : 0);
    end
    return r - w - 1;
  endfunction

  function automatic int unsigned step_index(input int unsigned idx, input int unsigned k,
                                             input int unsigned n);
    return (idx + k >= n) ? 0 : idx + k;
  endfunction

  // Apply one command to the mirror and return the beat it must produce.
  function automatic ring_view_t apply_action(input logic [2:0] act,
                                              input logic [BYTE_W-1:0] db,
                                              input logic [CNT_W-1:0] cnt);
    int unsigned s;
    int unsigned n;
    int unsigned k;
    int unsigned held;
    int unsigned rl;
    int unsigned wl;
    ring_view_t  v;
    s    = usable();
    n    = s + 1;
    k    = cnt;
    held = bytes_held(rd_q, wr_q, n);
    rl   = read_run(rd_q, wr_q, n);
    wl   = write_run(rd_q, wr_q, n);
    v    = '0;
    case (act)
      ACT_PUT: begin
        if (held == s) begin
          v.st = ST_FULL;
        end else begin
          shadow_mem[wr_q] = db;
          wr_q = step_index(wr_q, 1, n);
        end
      end
      ACT_GET: begin
        if (held == 0) begin
          v.st = ST_EMPTY;
        end else begin
          v.rdata = shadow_mem[rd_q];
          rd_q = step_index(rd_q, 1, n);
        end
      end
      ACT_RDAT: begin
        if (k >= rl) v.st = ST_BEYOND;
        else v.rdata = shadow_mem[rd_q + k];
      end
      ACT_WRAT: begin
        if (k >= wl) v.st = ST_BEYOND;
        else shadow_mem[wr_q + k] = db;
      end
      ACT_CONS: begin
        if (k > rl) v.st = ST_BEYOND;
        else rd_q = step_index(rd_q, k, n);
      end
      ACT_PROD: begin
        if (k > wl) v.st = ST_BEYOND;
        else wr_q = step_index(wr_q, k, n);
      end
      default: ;
    endcase
    held       = bytes_held(rd_q, wr_q, n);
    v.fill     = IDX_W'(held);
    v.space    = IDX_W'(s - held);
    v.full     = (held == s);
    v.empty    = (rd_q == wr_q);
    v.rs_start = IDX_W'(rd_q);
    v.rs_len   = IDX_W'(read_run(rd_q, wr_q, n));
    v.ws_start = IDX_W'(wr_q);
    v.ws_len   = IDX_W'(write_run(rd_q, wr_q, n));
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [IDX_W-1:0] got,
                                 input logic [IDX_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ring_view_t want;
    if (rst) begin
      cap_q = BUF_SIZE_RST;
      rd_q  = 0;
      wr_q  = 0;
      due_views.delete();
    end else begin
      if (done === 1'b1) begin
        if (due_views.size() == 0) begin
          report_mismatch("done with no command outstanding", 1, 0);
        end else begin
          want = due_views.pop_front();
          if (read_data !== want.rdata) report_mismatch("read_data", read_data, want.rdata);
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (fill_level !== want.fill) report_mismatch("fill_level", fill_level, want.fill);
          if (free_space !== want.space) report_mismatch("free_space", free_space, want.space);
          if (is_full !== want.full) report_mismatch("is_full", is_full, want.full);
          if (is_empty !== want.empty) report_mismatch("is_empty", is_empty, want.empty);
          if (read_slice_start !== want.rs_start)
            report_mismatch("read_slice_start", read_slice_start, want.rs_start);
          if (read_slice_len !== want.rs_len)
            report_mismatch("read_slice_len", read_slice_len, want.rs_len);
          if (write_slice_start !== want.ws_start)
            report_mismatch("write_slice_start", write_slice_start, want.ws_start);
          if (write_slice_len !== want.ws_len)
            report_mismatch("write_slice_len", write_slice_len, want.ws_len);
          beats_checked++;
        end
      end else if (done !== 1'b0) begin
        report_mismatch("done", done, 0);
      end
      if (cfg_wr_en) begin
        cap_q = cfg_wr_data;
        rd_q  = 0;
        wr_q  = 0;
      end
      if (start && !busy) due_views.push_back(apply_action(action, data_byte, count));
    end
    outstanding <= due_views.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Bench top for the byte ring buffer: clock, reset, command and capacity stimulus,
// and the verdict. Depends on brb_pkg, byte_ring_buffer_with_slices, ring_checker.
module tb_top;
  import brb_pkg::*;

  localparam int          MEM_CELLS = 1024;
  localparam int unsigned LIMIT     = 100000;
  // Code 7 is unused by the block and must behave as a nop.
  localparam logic [2:0]  ACT_SPARE = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [2:0]        action = ACT_NOP;
  logic [BYTE_W-1:0] data_byte = '0;
  logic [CNT_W-1:0]  count = '0;
  logic              cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]  cfg_wr_data = '0;

  logic              busy;
  logic              done;
  logic [BYTE_W-1:0] read_data;
  logic [1:0]        status;
  logic [IDX_W-1:0]  fill_level;
  logic [IDX_W-1:0]  free_space;
  logic              is_full;
  logic              is_empty;
  logic [IDX_W-1:0]  read_slice_start;
  logic [IDX_W-1:0]  read_slice_len;
  logic [IDX_W-1:0]  write_slice_start;
  logic [IDX_W-1:0]  write_slice_len;

  int                mismatches;
  int                outstanding;
  int                beats_checked;

  // Stimulus-side view of the ring. It only steers the generator: reads must
  // never land on a cell that was never written, and legal offsets and runs
  // depend on where the indices sit. The store is not cleared by a capacity
  // write, so the written marks survive it.
  int unsigned       ring_cap = BUF_SIZE_RST;
  int unsigned       ring_rd;
  int unsigned       ring_wr;
  bit                cell_written [MEM_CELLS];

  int unsigned       sent;
  int unsigned       refused;
  int unsigned       settings = 1;
  int unsigned       cycles;
  bit                quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_ring_buffer_with_slices #(.MEM_CELLS(MEM_CELLS)) uut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .data_byte         (data_byte),
    .count             (count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .done              (done),
    .read_data         (read_data),
    .status            (status),
    .fill_level        (fill_level),
    .free_space        (free_space),
    .is_full           (is_full),
    .is_empty          (is_empty),
    .read_slice_start  (read_slice_start),
    .read_slice_len    (read_slice_len),
    .write_slice_start (write_slice_start),
    .write_slice_len   (write_slice_len)
  );

  ring_checker #(.MEM_CELLS(MEM_CELLS)) chk (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .action            (action),
    .data_byte         (data_byte),
    .count             (count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .done              (done),
    .read_data         (read_data),
    .status            (status),
    .fill_level        (fill_level),
    .free_space        (free_space),
    .is_full           (is_full),
    .is_empty          (is_empty),
    .read_slice_start  (read_slice_start),
    .read_slice_len    (read_slice_len),
    .write_slice_start (write_slice_start),
    .write_slice_len   (write_slice_len),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .beats_checked     (beats_checked)
  );

  // Watchdog: declare a failure and stop if the run goes on past LIMIT.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles with %0d beats outstanding", cycles, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned fill_now();
    return (ring_rd <= ring_wr) ? ring_wr - ring_rd : ring_cap + 1 - (ring_rd - ring_wr);
  endfunction

  function automatic int unsigned read_room();
    return (ring_rd <= ring_wr) ? ring_wr - ring_rd : ring_cap + 1 - ring_rd;
  endfunction

  function automatic int unsigned write_room();
    if (ring_wr >= ring_rd) begin
      return ring_cap + 1 - ring_wr - ((ring_rd == 0) ? 1 : 0);
    end
    return ring_rd - ring_wr - 1;
  endfunction

  function automatic int unsigned bump(input int unsigned idx, input int unsigned k);
    return (idx + k >= ring_cap + 1) ? 0 : idx + k;
  endfunction

  // Legal run or offset up to hi; half the time keep it short so that small
  // steps and wraps both show up.
  function automatic int unsigned pick_upto(input int unsigned hi);
    if ($urandom_range(0, 1) == 0 && hi > 8) return $urandom_range(8, 0);
    return $urandom_range(hi, 0);
  endfunction

  // Out-of-slice value from lo up to the top of the count field.
  function automatic int unsigned pick_past(input int unsigned lo);
    return $urandom_range(1023, lo);
  endfunction

  // Advance the stimulus view once a command beat is taken.
  task automatic track_cmd(input logic [2:0] act, input logic [CNT_W-1:0] cnt);
    int unsigned k;
    k = cnt;
    case (act)
      ACT_PUT: begin
        if (fill_now() < ring_cap) begin
          cell_written[ring_wr] = 1'b1;
          ring_wr = bump(ring_wr, 1);
        end else refused++;
      end
      ACT_GET: begin
        if (fill_now() != 0) ring_rd = bump(ring_rd, 1);
        else refused++;
      end
      ACT_RDAT: begin
        if (k >= read_room()) refused++;
      end
      ACT_WRAT: begin
        if (k < write_room()) cell_written[ring_wr + k] = 1'b1;
        else refused++;
      end
      ACT_CONS: begin
        if (k <= read_room()) ring_rd = bump(ring_rd, k);
        else refused++;
      end
      ACT_PROD: begin
        if (k <= write_room()) ring_wr = bump(ring_wr, k);
        else refused++;
      end
      default: ;
    endcase
  endtask

  // Drive one command beat after a random idle gap (none in quiet stretches),
  // and hold it until the block takes it.
  task automatic feed(input logic [2:0] act, input logic [BYTE_W-1:0] db,
                      input logic [CNT_W-1:0] cnt);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(6, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    action    <= act;
    data_byte <= db;
    count     <= cnt;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    track_cmd(act, cnt);
    sent++;
  endtask

  // Drop start and wait until every result beat is in, then let the
  // pipe drain a little more.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // A capacity write also resets both indices, so the ring comes back empty.
  task automatic set_capacity(input logic [IDX_W-1:0] cap);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ring_cap = cap;
    ring_rd  = 0;
    ring_wr  = 0;
    settings++;
  endtask

  // Mostly well-formed traffic with random content, plus a share of full
  // puts, empty gets and out-of-slice offsets and runs.
  task automatic random_run(input int unsigned items);
    logic [2:0]        act;
    logic [BYTE_W-1:0] db;
    logic [CNT_W-1:0]  cnt;
    int unsigned       held;
    int unsigned       rl;
    int unsigned       wl;
    int unsigned       roll;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(3, 0) == 0);
      held = fill_now();
      rl   = read_room();
      wl   = write_room();
      db   = BYTE_W'($urandom);
      cnt  = CNT_W'($urandom);
      roll = $urandom_range(99, 0);
      if (roll < 5) begin
        act = ($urandom_range(1, 0) == 0) ? ACT_NOP : ACT_SPARE;
      end else if (roll < 30) begin
        act = ACT_PUT;
      end else if (roll < 50) begin
        act = ACT_GET;
        // Skip a cell left unwritten by a produce: drop it instead of reading.
        if (held != 0 && !cell_written[ring_rd]) begin
          act = ACT_CONS;
          cnt = 10'd1;
        end
      end else if (roll < 65) begin
        act = ACT_RDAT;
        if (rl != 0 && $urandom_range(9, 0) < 8) begin
          cnt = CNT_W'(pick_upto(rl - 1));
          if (!cell_written[ring_rd + cnt]) begin
            act = ACT_CONS;
            cnt = 10'd1;
          end
        end else begin
          cnt = CNT_W'(pick_past(rl));
        end
      end else if (roll < 80) begin
        act = ACT_WRAT;
        if (wl != 0 && $urandom_range(9, 0) < 8) cnt = CNT_W'(pick_upto(wl - 1));
        else cnt = CNT_W'(pick_past(wl));
      end else if (roll < 90) begin
        act = ACT_CONS;
        if (rl == 1023 || $urandom_range(9, 0) < 8) cnt = CNT_W'(pick_upto(rl));
        else cnt = CNT_W'(pick_past(rl + 1));
      end else begin
        act = ACT_PROD;
        if (wl == 1023 || $urandom_range(9, 0) < 8) cnt = CNT_W'(pick_upto(wl));
        else cnt = CNT_W'(pick_past(wl + 1));
      end
      feed(act, db, cnt);
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [IDX_W-1:0] caps [9];
    caps = '{10'd3, 10'd0, 10'd1, 10'd1023, 10'd2, 10'd16, 10'd700, 10'd5, 10'd1023};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset capacity: a nop, an empty get, a beyond-slice read on an empty ring,
    // the spare action code, a produce that fills the whole ring without data, put and
    // beyond-slice write when full, then drain and wrap a single byte through the last cell.
    feed(ACT_NOP,   8'h00, 10'd0);
    feed(ACT_GET,   8'h00, 10'd0);
    feed(ACT_RDAT,  8'h00, 10'd0);
    feed(ACT_SPARE, 8'hFF, 10'd1023);
    feed(ACT_PROD,  8'h00, 10'd1023);
    feed(ACT_PUT,   8'hAA, 10'd0);
    feed(ACT_WRAT,  8'h55, 10'd0);
    feed(ACT_CONS,  8'h00, 10'd1023);
    feed(ACT_PUT,   8'h00, 10'd0);
    feed(ACT_GET,   8'hFF, 10'd0);

    // Capacity of three: fill to full, every out-of-slice case, in-slice
    // write, a produce that wraps the write index, and reads across the wrap.
    set_capacity(caps[0]);
    feed(ACT_PUT,  8'hFF, 10'd0);
    feed(ACT_PUT,  8'h5A, 10'd0);
    feed(ACT_PUT,  8'hA5, 10'd0);
    feed(ACT_PUT,  8'h11, 10'd0);
    feed(ACT_RDAT, 8'h00, 10'd2);
    feed(ACT_RDAT, 8'h00, 10'd3);
    feed(ACT_CONS, 8'h00, 10'd4);
    feed(ACT_CONS, 8'h00, 10'd2);
    feed(ACT_WRAT, 8'h3C, 10'd0);
    feed(ACT_WRAT, 8'hC3, 10'd1);
    feed(ACT_PROD, 8'h00, 10'd2);
    feed(ACT_PROD, 8'h00, 10'd1);
    feed(ACT_RDAT, 8'h00, 10'd1);
    feed(ACT_GET,  8'h00, 10'd0);
    feed(ACT_GET,  8'h00, 10'd0);
    feed(ACT_GET,  8'h00, 10'd0);

    // Random traffic through the capacity sweep, extremes included.
    for (int p = 0; p < 9; p++) begin
      if (p != 0) set_capacity(caps[p]);
      random_run(100);
    end

    settle();
    $display("Sent %0d commands (%0d refused by the ring) over %0d capacity settings;",
             sent, refused, settings);
    $display("checked %0d result beats field by field.", beats_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ byte_ring_buffer_with_slices.f @@
hdl/brb_pkg.sv
hdl/brb_mem.sv
hdl/brb_ctrl.sv
hdl/byte_ring_buffer_with_slices.sv
sim/ring_checker.sv
sim/tb_top.sv
